@@ design/icph_pkg.sv @@
`default_nettype none

package icph_pkg;

  // configuration register reset values
  localparam logic       PSEUDO_RESET = 1'b0;
  localparam logic [7:0] PROTO_RESET  = 8'd17;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_PSEUDO_ENABLE   = 1'b0,
    REG_PROTOCOL_NUMBER = 1'b1
  } reg_index_t;

  // live configuration
  typedef struct packed {
    logic       pseudo_enable;
    logic [7:0] protocol_number;
  } cfg_t;

  // packet summary handed to the final fold stage
  typedef struct packed {
    logic [15:0] sum;
    logic [31:0] length;
    logic        pseudo;
    logic [7:0]  proto;
  } fin_t;

  // one's-complement 16-bit add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

`default_nettype wire

@@ design/icph_cfg.sv @@
`default_nettype none

module icph_cfg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire icph_pkg::reg_index_t   cfg_index,
  input  wire logic [7:0]             cfg_data,
  output icph_pkg::cfg_t              cfg
);
  import icph_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pseudo_enable   <= PSEUDO_RESET;
      cfg.protocol_number <= PROTO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PSEUDO_ENABLE:   cfg.pseudo_enable   <= cfg_data[0];
        REG_PROTOCOL_NUMBER: cfg.protocol_number <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/icph_acc.sv @@
`default_nettype none

module icph_acc (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire logic [7:0]       data_byte,
  input  wire logic             is_address,
  input  wire logic             last_byte,
  input  wire icph_pkg::cfg_t   cfg,
  input  wire logic             fin_take,
  output logic                  fin_valid,
  output icph_pkg::fin_t        fin
);
  import icph_pkg::*;

  logic [15:0] running_sum;
  logic [7:0]  held_high_byte;
  logic        byte_odd;
  logic [31:0] transport_length;

  logic        accept;
  logic [31:0] length_next;
  logic [15:0] pair_word;
  logic [15:0] sum_next;

  // a last byte needs the summary slot free; every byte stalls while it is held
  assign item_stall = fin_valid && !fin_take;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    length_next = transport_length + {31'b0, !is_address};
    // completes the held pair, or pads a lone high byte with a zero low byte
    pair_word   = byte_odd ? {held_high_byte, data_byte} : {data_byte, 8'h00};
    sum_next    = oc_add(running_sum, pair_word);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum      <= '0;
      held_high_byte   <= '0;
      byte_odd         <= 1'b0;
      transport_length <= '0;
      fin_valid        <= 1'b0;
    end else begin
      if (fin_take) begin
        fin_valid <= 1'b0;
      end
      if (accept) begin
        if (last_byte) begin
          fin_valid        <= 1'b1;
          fin.sum          <= sum_next;
          fin.length       <= length_next;
          fin.pseudo       <= cfg.pseudo_enable;
          fin.proto        <= cfg.protocol_number;
          running_sum      <= '0;
          held_high_byte   <= '0;
          byte_odd         <= 1'b0;
          transport_length <= '0;
        end else begin
          transport_length <= length_next;
          if (byte_odd) begin
            running_sum    <= sum_next;
            held_high_byte <= '0;
            byte_odd       <= 1'b0;
          end else begin
            held_high_byte <= data_byte;
            byte_odd       <= 1'b1;
          end
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> fin_valid && !byte_odd && transport_length == '0
      && running_sum == '0)
    else $error("state not cleared after last byte");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> fin_valid)
    else $error("input stalled with empty summary slot");
`endif

endmodule

`default_nettype wire

@@ design/icph_fold.sv @@
`default_nettype none

module icph_fold (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fin_valid,
  input  wire icph_pkg::fin_t   fin,
  output logic                  fin_take,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output logic [15:0]           checksum
);
  import icph_pkg::*;

  logic        load;
  logic [17:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign load     = !result_valid || !result_stall;
  assign fin_take = fin_valid && load;

  // sum all words wide, then two end-around folds
  always_comb begin
    total = {2'b0, fin.sum};
    if (fin.pseudo) begin
      total = total + {2'b0, fin.length[31:16]} + {2'b0, fin.length[15:0]}
            + {10'b0, fin.proto};
    end
    fold1 = {1'b0, total[15:0]} + {15'b0, total[17:16]};
    fold2 = fold1[15:0] + {15'b0, fold1[16]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      checksum <= ~fold2;
    end
  end

`ifndef NO_ASSERTIONS
  a_take_shows: assert property (@(posedge clk) disable iff (rst)
    fin_take |=> result_valid)
    else $error("taken summary did not reach the result register");
`endif

endmodule

`default_nettype wire

@@ design/internet_checksum_pseudo_header.sv @@
// Streaming internet checksum with optional IPv6 pseudo-header.
// Byte channel: item_valid / item_stall carry data_byte, is_address and
//   last_byte; a transfer happens when item_valid is high and item_stall low.
//   Bytes come in wire order, address bytes first when pseudo mode is used.
// Result channel: result_valid / result_stall carry checksum, one result per
//   packet, sent after the transfer of the byte flagged last_byte.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
//   is pseudo_enable, index 1 is protocol_number. cfg_ready is always high.
// Throughput: one byte per cycle while item_stall is low, including back-to-back packets.
// Result path: the last byte's transfer loads the summary register, then the
//   fold moves it into the result register when that register can load.
// Reset (rst, synchronous): clears the running sum, byte pairing and length,
//   empties both registers; pseudo_enable = 0, protocol_number = 17.
// Receiver stall: the result register holds; one more packet end can wait in
//   the summary register, after that item_stall rises until the result moves.
`default_nettype none

module internet_checksum_pseudo_header (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // byte channel
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   is_address,
  input  wire logic                   last_byte,
  // result channel
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic [15:0]                 checksum,
  // config channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire icph_pkg::reg_index_t   cfg_index,
  input  wire logic [7:0]             cfg_data
);
  import icph_pkg::*;

  cfg_t cfg;
  fin_t fin;
  logic fin_valid;
  logic fin_take;

  // configuration registers
  icph_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // byte pairing, running sum, length count; packet summary on last byte
  icph_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .data_byte  (data_byte),
    .is_address (is_address),
    .last_byte  (last_byte),
    .cfg        (cfg),
    .fin_take   (fin_take),
    .fin_valid  (fin_valid),
    .fin        (fin)
  );

  // pseudo-header words, final fold, complement, result register
  icph_fold u_fold (
    .clk          (clk),
    .rst          (rst),
    .fin_valid    (fin_valid),
    .fin          (fin),
    .fin_take     (fin_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .checksum     (checksum)
  );

endmodule

`default_nettype wire
